@@ sv/sfla_pkg.sv @@
package sfla_pkg;

    // Fixed field and storage widths.
    localparam int ADDR_W     = 16;
    localparam int REQ_W      = 16;
    localparam int ALIGN_W    = 13;
    localparam int SIZE_W     = 17;
    localparam int LINK_W     = 17;
    localparam int DIVD_W     = 17;
    localparam int STEP_W     = 17;
    localparam int CNT_W      = 5;
    localparam int CLASS_W    = 4;
    localparam int CLASS_COUNT = 10;
    localparam int ARENA_DEPTH = 65536;
    localparam int IN_DATA_W  = 48;
    localparam int OUT_DATA_W = 24;

    // Defaults for the top-level parameters.
    localparam int DEF_PAGE_BYTES   = 8192;
    localparam int DEF_PAGE_COUNT   = 8;
    localparam int DEF_HEADER_BYTES = 16;

    // Classes that are searched first-fit instead of popped.
    localparam logic [CLASS_W-1:0] CLS_SMALL = CLASS_W'(0);
    localparam logic [CLASS_W-1:0] CLS_LARGE = CLASS_W'(CLASS_COUNT - 1);

    localparam logic [SIZE_W-1:0] CLASS_BOUND [CLASS_COUNT] = '{
        17'd0, 17'd32, 17'd64, 17'd128, 17'd256, 17'd512,
        17'd1024, 17'd2048, 17'd4096, 17'd0
    };

    typedef enum logic [1:0] {
        ST_ALLOCATED = 2'd0,
        ST_FREED     = 2'd1,
        ST_NO_MEMORY = 2'd2
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DIV,
        S_CALC,
        S_SELECT,
        S_FREE_RD,
        S_FREE_WR,
        S_SRCH_CHK,
        S_SRCH_EVAL,
        S_POP_RD,
        S_POP_TAKE,
        S_CARVE,
        S_DONE
    } state_t;

    // One block header: stored size and link to the next block of its list.
    typedef struct packed {
        logic [SIZE_W-1:0] size;
        logic [LINK_W-1:0] link;
    } hdr_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic latch_in;
        logic div_step;
        logic calc;
        logic select;
        logic free_rd;
        logic free_wr;
        logic srch_rd;
        logic srch_eval;
        logic pop_rd;
        logic pop_take;
        logic carve;
        logic out_load;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic in_free;
        logic in_align_zero;
        logic div_last;
        logic search_cls;
        logic head_valid;
        logic cur_go;
        logic fit;
        logic out_busy;
    } sts_t;

    // Class used when a block is requested.
    function automatic logic [CLASS_W-1:0] upper_class(input logic [SIZE_W-1:0] size);
        logic [CLASS_W-1:0] c;
        c = CLS_LARGE;
        for (int i = CLASS_COUNT - 2; i >= 0; i--) begin
            if (size <= CLASS_BOUND[i+1]) begin
                c = (i == 0) ? CLS_SMALL : CLASS_W'(i + 1);
            end
        end
        return c;
    endfunction

    // Class used when a block is returned.
    function automatic logic [CLASS_W-1:0] lower_class(input logic [SIZE_W-1:0] size);
        logic [CLASS_W-1:0] c;
        c = CLS_LARGE;
        for (int i = CLASS_COUNT - 2; i >= 0; i--) begin
            if (size < CLASS_BOUND[i+1]) begin
                c = CLASS_W'(i);
            end
        end
        return c;
    endfunction

endpackage

@@ sv/sfla_ram.sv @@
module sfla_ram #(
    parameter int DATA_W = 34,
    parameter int DEPTH  = 65536
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [DATA_W-1:0]        wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [DATA_W-1:0]        rdata
);

    logic [DATA_W-1:0] mem [DEPTH];

    // One write port and one registered read port.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ sv/sfla_ctrl.sv @@
module sfla_ctrl (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_tvalid,
    output logic            s_tready,
    input  sfla_pkg::sts_t  sts,
    output sfla_pkg::cmd_t  cmd
);

    sfla_pkg::state_t state_reg, state_next;

    // State register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= sfla_pkg::S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            sfla_pkg::S_IDLE: begin
                if (s_tvalid) begin
                    if (sts.in_free) begin
                        state_next = sfla_pkg::S_FREE_RD;
                    end else if (sts.in_align_zero) begin
                        state_next = sfla_pkg::S_CALC;
                    end else begin
                        state_next = sfla_pkg::S_DIV;
                    end
                end
            end
            sfla_pkg::S_DIV: begin
                if (sts.div_last) begin
                    state_next = sfla_pkg::S_CALC;
                end
            end
            sfla_pkg::S_CALC:    state_next = sfla_pkg::S_SELECT;
            sfla_pkg::S_SELECT: begin
                if (sts.search_cls) begin
                    state_next = sfla_pkg::S_SRCH_CHK;
                end else if (sts.head_valid) begin
                    state_next = sfla_pkg::S_POP_RD;
                end else begin
                    state_next = sfla_pkg::S_CARVE;
                end
            end
            sfla_pkg::S_FREE_RD: state_next = sfla_pkg::S_FREE_WR;
            sfla_pkg::S_FREE_WR: state_next = sfla_pkg::S_DONE;
            sfla_pkg::S_SRCH_CHK: begin
                state_next = sts.cur_go ? sfla_pkg::S_SRCH_EVAL : sfla_pkg::S_CARVE;
            end
            sfla_pkg::S_SRCH_EVAL: begin
                state_next = sts.fit ? sfla_pkg::S_DONE : sfla_pkg::S_SRCH_CHK;
            end
            sfla_pkg::S_POP_RD:   state_next = sfla_pkg::S_POP_TAKE;
            sfla_pkg::S_POP_TAKE: state_next = sfla_pkg::S_DONE;
            sfla_pkg::S_CARVE:    state_next = sfla_pkg::S_DONE;
            sfla_pkg::S_DONE: begin
                if (!sts.out_busy) begin
                    state_next = sfla_pkg::S_IDLE;
                end
            end
            default: state_next = sfla_pkg::S_IDLE;
        endcase
    end

    // Outputs.
    always_comb begin
        cmd      = '0;
        s_tready = 1'b0;
        unique case (state_reg)
            sfla_pkg::S_IDLE: begin
                s_tready     = 1'b1;
                cmd.latch_in = s_tvalid;
            end
            sfla_pkg::S_DIV:       cmd.div_step  = 1'b1;
            sfla_pkg::S_CALC:      cmd.calc      = 1'b1;
            sfla_pkg::S_SELECT:    cmd.select    = 1'b1;
            sfla_pkg::S_FREE_RD:   cmd.free_rd   = 1'b1;
            sfla_pkg::S_FREE_WR:   cmd.free_wr   = 1'b1;
            sfla_pkg::S_SRCH_CHK:  cmd.srch_rd   = sts.cur_go;
            sfla_pkg::S_SRCH_EVAL: cmd.srch_eval = 1'b1;
            sfla_pkg::S_POP_RD:    cmd.pop_rd    = 1'b1;
            sfla_pkg::S_POP_TAKE:  cmd.pop_take  = 1'b1;
            sfla_pkg::S_CARVE:     cmd.carve     = 1'b1;
            sfla_pkg::S_DONE:      cmd.out_load  = !sts.out_busy;
            default: ;
        endcase
    end

endmodule

@@ sv/sfla_dp.sv @@
module sfla_dp #(
    parameter int PAGE_BYTES   = sfla_pkg::DEF_PAGE_BYTES,
    parameter int PAGE_COUNT   = sfla_pkg::DEF_PAGE_COUNT,
    parameter int HEADER_BYTES = sfla_pkg::DEF_HEADER_BYTES
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           in_op,
    input  logic [sfla_pkg::REQ_W-1:0]     in_size,
    input  logic [sfla_pkg::ALIGN_W-1:0]   in_align,
    input  logic [sfla_pkg::ADDR_W-1:0]    in_faddr,
    input  sfla_pkg::cmd_t                 cmd,
    output sfla_pkg::sts_t                 sts,
    input  logic                           m_tready,
    output logic                           out_valid,
    output logic [sfla_pkg::ADDR_W-1:0]    out_addr,
    output logic [1:0]                     out_status
);

    localparam int FILL_W = $clog2(PAGE_BYTES + 1);
    localparam int PIDX_W = $clog2(PAGE_COUNT + 1);
    localparam int AW = sfla_pkg::ADDR_W;
    localparam int SW = sfla_pkg::SIZE_W;

    // Request registers.
    logic [sfla_pkg::REQ_W-1:0]    size_reg;
    logic [sfla_pkg::ALIGN_W-1:0]  align_reg;
    logic [AW-1:0]                 faddr_reg;

    // Remainder unit, one quotient bit per cycle.
    logic [sfla_pkg::ALIGN_W-1:0]  rem_reg;
    logic [sfla_pkg::DIVD_W-1:0]   divd_reg;
    logic [sfla_pkg::CNT_W-1:0]    cnt_reg;
    logic [sfla_pkg::ALIGN_W:0]    rem_sh;

    // Allocation state.
    logic [SW-1:0]                 req_reg;
    logic [SW-1:0]                 req_next;
    logic [sfla_pkg::CLASS_W-1:0]  cls_reg;
    logic [sfla_pkg::LINK_W-1:0]   heads_reg [sfla_pkg::CLASS_COUNT];
    logic [sfla_pkg::LINK_W-1:0]   head_sel;
    logic [sfla_pkg::LINK_W-1:0]   cur_reg;
    logic [AW-1:0]                 before_reg;
    logic                          have_before_reg;
    logic [SW-1:0]                 prev_size_reg;
    logic [sfla_pkg::STEP_W-1:0]   steps_reg;
    logic [FILL_W-1:0]             fill_reg;
    logic [PIDX_W-1:0]             pidx_reg;
    logic [AW-1:0]                 base_reg;

    // Result staging and the output register.
    logic [AW-1:0]                 res_addr_reg;
    logic [1:0]                    res_status_reg;
    logic                          out_valid_reg;
    logic [AW-1:0]                 out_addr_reg;
    logic [1:0]                    out_status_reg;

    // Header memory ports.
    logic                          mem_we;
    logic [AW-1:0]                 mem_waddr;
    sfla_pkg::hdr_t                mem_wdata;
    logic [AW-1:0]                 mem_raddr;
    sfla_pkg::hdr_t                mem_q;

    logic [AW-1:0]                 free_node;
    logic [sfla_pkg::CLASS_W-1:0]  free_cls;
    logic [SW:0]                   need;
    logic                          too_big;
    logic                          overflow;
    logic                          last_page;
    logic                          carve_fail;
    logic [AW-1:0]                 base_use;
    logic [FILL_W-1:0]             fill_use;
    logic [AW-1:0]                 carve_node;
    logic [SW-1:0]                 pad;

    sfla_ram #(
        .DATA_W ($bits(sfla_pkg::hdr_t)),
        .DEPTH  (sfla_pkg::ARENA_DEPTH)
    ) u_hdr_ram (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_q)
    );

    // Combinational helpers.
    always_comb begin
        head_sel   = (cls_reg < sfla_pkg::CLASS_W'(sfla_pkg::CLASS_COUNT))
                     ? heads_reg[cls_reg] : '0;
        free_node  = faddr_reg - AW'(HEADER_BYTES);
        free_cls   = sfla_pkg::lower_class(mem_q.size);
        rem_sh     = {rem_reg, divd_reg[sfla_pkg::DIVD_W-1]};
        pad        = (align_reg == '0) ? '0 : (SW'(align_reg) - SW'(rem_reg));
        req_next   = SW'(size_reg) + pad;
        need       = (SW+1)'(req_reg) + (SW+1)'(HEADER_BYTES);
        too_big    = need > (SW+1)'(PAGE_BYTES);
        overflow   = ((SW+2)'(fill_reg) + (SW+2)'(need)) > (SW+2)'(PAGE_BYTES);
        last_page  = ((PIDX_W+1)'(pidx_reg) + (PIDX_W+1)'(1)) >= (PIDX_W+1)'(PAGE_COUNT);
        carve_fail = too_big || (overflow && last_page);
        base_use   = overflow ? (base_reg + AW'(PAGE_BYTES)) : base_reg;
        fill_use   = overflow ? '0 : fill_reg;
        carve_node = base_use + AW'(fill_use);
    end

    // Header memory read and write selection.
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = carve_node;
        mem_wdata = '{size: req_reg, link: '0};
        if (cmd.free_rd) begin
            mem_raddr = free_node;
        end else if (cmd.pop_rd) begin
            mem_raddr = head_sel[AW-1:0];
        end else begin
            mem_raddr = cur_reg[AW-1:0];
        end
        priority if (cmd.free_wr) begin
            mem_we    = 1'b1;
            mem_waddr = free_node;
            mem_wdata = '{size: mem_q.size, link: heads_reg[free_cls]};
        end else if (cmd.srch_eval && mem_q.size >= req_reg && have_before_reg) begin
            mem_we    = 1'b1;
            mem_waddr = before_reg;
            mem_wdata = '{size: prev_size_reg, link: mem_q.link};
        end else if (cmd.carve && !carve_fail) begin
            mem_we    = 1'b1;
        end else begin
            mem_we    = 1'b0;
        end
    end

    // Request, remainder, search, result and output registers without reset.
    always_ff @(posedge aclk) begin
        if (cmd.latch_in) begin
            size_reg  <= in_size;
            align_reg <= in_align;
            faddr_reg <= in_faddr;
            rem_reg   <= '0;
            divd_reg  <= sfla_pkg::DIVD_W'(in_size) + sfla_pkg::DIVD_W'(HEADER_BYTES);
            cnt_reg   <= sfla_pkg::CNT_W'(sfla_pkg::DIVD_W);
        end
        if (cmd.div_step) begin
            if (rem_sh >= {1'b0, align_reg}) begin
                rem_reg <= sfla_pkg::ALIGN_W'(rem_sh - {1'b0, align_reg});
            end else begin
                rem_reg <= rem_sh[sfla_pkg::ALIGN_W-1:0];
            end
            divd_reg <= divd_reg << 1;
            cnt_reg  <= cnt_reg - sfla_pkg::CNT_W'(1);
        end
        if (cmd.calc) begin
            req_reg <= req_next;
            cls_reg <= sfla_pkg::upper_class(req_next);
        end
        if (cmd.select) begin
            cur_reg         <= head_sel;
            have_before_reg <= 1'b0;
            steps_reg       <= '0;
        end
        if (cmd.srch_eval && mem_q.size < req_reg) begin
            before_reg      <= cur_reg[AW-1:0];
            prev_size_reg   <= mem_q.size;
            have_before_reg <= 1'b1;
            cur_reg         <= mem_q.link;
            steps_reg       <= steps_reg + sfla_pkg::STEP_W'(1);
        end
        // Result of the finished request.
        if (cmd.free_wr) begin
            res_addr_reg   <= '0;
            res_status_reg <= sfla_pkg::ST_FREED;
        end
        if ((cmd.srch_eval && mem_q.size >= req_reg) || cmd.pop_take) begin
            res_addr_reg   <= ((cmd.pop_take ? head_sel[AW-1:0] : cur_reg[AW-1:0])
                               + AW'(HEADER_BYTES));
            res_status_reg <= sfla_pkg::ST_ALLOCATED;
        end
        if (cmd.carve) begin
            res_addr_reg   <= carve_fail ? '0 : (carve_node + AW'(HEADER_BYTES));
            res_status_reg <= carve_fail ? sfla_pkg::ST_NO_MEMORY : sfla_pkg::ST_ALLOCATED;
        end
        if (cmd.out_load) begin
            out_addr_reg   <= res_addr_reg;
            out_status_reg <= res_status_reg;
        end
    end

    // List heads, page state and output valid.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < sfla_pkg::CLASS_COUNT; i++) begin
                heads_reg[i] <= '0;
            end
            fill_reg      <= '0;
            pidx_reg      <= '0;
            base_reg      <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cmd.free_wr) begin
                heads_reg[free_cls] <= {1'b1, free_node};
            end
            if (cmd.srch_eval && mem_q.size >= req_reg && !have_before_reg) begin
                heads_reg[cls_reg] <= mem_q.link;
            end
            if (cmd.pop_take) begin
                heads_reg[cls_reg] <= mem_q.link;
            end
            if (cmd.carve && !carve_fail) begin
                fill_reg <= FILL_W'((SW+2)'(fill_use) + (SW+2)'(need));
                base_reg <= base_use;
                if (overflow) begin
                    pidx_reg <= pidx_reg + PIDX_W'(1);
                end
            end
            if (cmd.out_load) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Status to the controller.
    always_comb begin
        sts.in_free       = in_op;
        sts.in_align_zero = (in_align == '0);
        sts.div_last      = (cnt_reg == sfla_pkg::CNT_W'(1));
        sts.search_cls    = (cls_reg == sfla_pkg::CLS_SMALL) || (cls_reg == sfla_pkg::CLS_LARGE);
        sts.head_valid    = head_sel[sfla_pkg::LINK_W-1];
        sts.cur_go        = cur_reg[sfla_pkg::LINK_W-1] && !steps_reg[sfla_pkg::STEP_W-1];
        sts.fit           = mem_q.size >= req_reg;
        sts.out_busy      = out_valid_reg && !m_tready;
    end

    assign out_valid  = out_valid_reg;
    assign out_addr   = out_addr_reg;
    assign out_status = out_status_reg;

endmodule

@@ sv/segregated_free_list_allocator.sv @@
// Channel   Dir  Handshake           Payload
// s_*       in   s_tvalid/s_tready   operation, request_size, align_bytes, free_address
// m_*       out  m_tvalid/m_tready   block_address, status
//
// A free is accepted, reads and rewrites the block header, then gives its result.
// An allocate is accepted, iterates the remainder when align_bytes is nonzero,
// is sized and classified, then pops a list head, or visits list nodes in
// classes 0 and 9 with a final check when the list runs out, carves a block
// when nothing was taken, and gives its result. Each node costs a read of the header memory.
// Reset empties every list and rewinds to page zero; the header memory is not
// cleared. The result sits in an output register; while it waits on m_tready,
// the next request is still processed but holds in its result cycle.
module segregated_free_list_allocator #(
    parameter int PAGE_BYTES   = sfla_pkg::DEF_PAGE_BYTES,
    parameter int PAGE_COUNT   = sfla_pkg::DEF_PAGE_COUNT,
    parameter int HEADER_BYTES = sfla_pkg::DEF_HEADER_BYTES
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // operation [0], request_size [16:1], align_bytes [29:17], free_address [45:30]
    input  logic [sfla_pkg::IN_DATA_W-1:0]    s_tdata,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // block_address [15:0], status [17:16]
    output logic [sfla_pkg::OUT_DATA_W-1:0]   m_tdata
);

    sfla_pkg::cmd_t                 cmd;
    sfla_pkg::sts_t                 sts;
    logic [sfla_pkg::ADDR_W-1:0]    out_addr;
    logic [1:0]                     out_status;

    sfla_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    sfla_dp #(
        .PAGE_BYTES   (PAGE_BYTES),
        .PAGE_COUNT   (PAGE_COUNT),
        .HEADER_BYTES (HEADER_BYTES)
    ) u_dp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_op      (s_tdata[0]),
        .in_size    (s_tdata[16:1]),
        .in_align   (s_tdata[29:17]),
        .in_faddr   (s_tdata[45:30]),
        .cmd        (cmd),
        .sts        (sts),
        .m_tready   (m_tready),
        .out_valid  (m_tvalid),
        .out_addr   (out_addr),
        .out_status (out_status)
    );

    assign m_tdata = {6'b0, out_status, out_addr};

    // One request at a time: an accepted transaction closes the input side.
    a_single_item: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted while a request is in progress");

    // Status code three never appears.
    a_status_legal: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[17:16] != 2'd3))
        else $error("illegal status code");

    // Frees and failures carry a zero address.
    a_zero_addr: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[17:16] != 2'd0) |-> (m_tdata[15:0] == 16'd0))
        else $error("nonzero address on a free or failed allocate");

    // A fresh result appears only right after the input side was closed.
    a_result_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(!s_tready))
        else $error("result produced while idle");

endmodule
